>>> rtl/core/rc4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 9;
  localparam int PERM_DEPTH      = 256;
  localparam int KEY_MAX_LEN_DEF = 256;

  localparam logic [LEN_W-1:0] KEY_LEN_RST = LEN_W'(16);

  localparam logic [1:0] OP_KEY     = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_DATA    = 2'd2;

  // permutation read address select
  localparam logic [1:0] RSEL_NEXT = 2'd0;
  localparam logic [1:0] RSEL_CUR  = 2'd1;
  localparam logic [1:0] RSEL_SUMJ = 2'd2;
  localparam logic [1:0] RSEL_KS   = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] key_index;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher_byte;
    logic [BYTE_W-1:0] keystream_byte;
  } out_item_t;

  typedef struct packed {
    logic       key_wr;
    logic       latch_data;
    logic       clr_idx;
    logic       fill;
    logic [1:0] rsel;
    logic       step_j;
    logic       use_key;
    logic       inc_i;
    logic       wr_j;
    logic       wr_i;
    logic       adv_k;
    logic       clr_j;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/rc4_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/rc4_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl
  import rc4_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_opcode,
  output logic            in_ready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FILL = 4'd1;
  localparam logic [3:0] ST_SA   = 4'd2;
  localparam logic [3:0] ST_SB   = 4'd3;
  localparam logic [3:0] ST_SC   = 4'd4;
  localparam logic [3:0] ST_SD   = 4'd5;
  localparam logic [3:0] ST_RJ   = 4'd6;
  localparam logic [3:0] ST_W1   = 4'd7;
  localparam logic [3:0] ST_W2   = 4'd8;
  localparam logic [3:0] ST_KS   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       keyed_r, keyed_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    keyed_nxt = keyed_r;
    cmd       = '0;
    cmd.rsel  = RSEL_NEXT;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_KEY: begin
              cmd.key_wr = 1'b1;
            end
            OP_RESTART: begin
              cmd.clr_idx = 1'b1;
              state_nxt   = ST_FILL;
            end
            OP_DATA: begin
              if (keyed_r) begin
                cmd.latch_data = 1'b1;
                state_nxt      = ST_RJ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.i_last) begin
          state_nxt = ST_SA;
        end
      end
      ST_SA: begin
        cmd.rsel  = RSEL_CUR;
        state_nxt = ST_SB;
      end
      ST_SB: begin
        cmd.rsel    = RSEL_SUMJ;
        cmd.step_j  = 1'b1;
        cmd.use_key = 1'b1;
        state_nxt   = ST_SC;
      end
      ST_SC: begin
        cmd.wr_j  = 1'b1;
        state_nxt = ST_SD;
      end
      ST_SD: begin
        cmd.wr_i  = 1'b1;
        cmd.inc_i = 1'b1;
        cmd.adv_k = 1'b1;
        if (sts.i_last) begin
          cmd.clr_j = 1'b1;
          keyed_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SA;
        end
      end
      ST_RJ: begin
        cmd.rsel   = RSEL_SUMJ;
        cmd.step_j = 1'b1;
        cmd.inc_i  = 1'b1;
        state_nxt  = ST_W1;
      end
      ST_W1: begin
        cmd.wr_j  = 1'b1;
        state_nxt = ST_W2;
      end
      ST_W2: begin
        cmd.wr_i  = 1'b1;
        cmd.rsel  = RSEL_KS;
        state_nxt = ST_KS;
      end
      ST_KS: begin
        // keep the keystream address on the RAM while the output is stalled
        cmd.rsel = RSEL_KS;
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      keyed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      keyed_r <= keyed_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rc4_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4_dp
  import rc4_pkg::*;
#(
  parameter int KEY_MAX_LEN = KEY_MAX_LEN_DEF,
  localparam int KAW        = (KEY_MAX_LEN > 1) ? $clog2(KEY_MAX_LEN) : 1,
  localparam int PAW        = $clog2(PERM_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire in_item_t         in_data,
  input  wire logic             cfg_valid,
  input  wire logic [LEN_W-1:0] cfg_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  localparam logic [LEN_W-1:0] KMAX = LEN_W'(KEY_MAX_LEN);

  logic [PAW-1:0]    i_r, i_nxt;
  logic [PAW-1:0]    j_r, j_nxt;
  logic [KAW-1:0]    k_r, k_nxt;
  logic [BYTE_W-1:0] sa_r, sb_r, data_r;
  logic              hit_r;
  logic [LEN_W-1:0]  key_len_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [BYTE_W-1:0] perm_rd, key_rd, j_sum, t_addr, ks;
  logic [PAW-1:0]    perm_raddr, perm_waddr;
  logic [BYTE_W-1:0] perm_wdata;
  logic              perm_we, key_we, k_last;
  logic [LEN_W-1:0]  len_eff;

  assign j_sum  = j_r + perm_rd + (cmd.use_key ? key_rd : BYTE_W'(0));
  assign t_addr = sa_r + sb_r;
  assign ks     = hit_r ? sb_r : perm_rd;

  always_comb begin
    if (key_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_len_r > KMAX) begin
      len_eff = KMAX;
    end else begin
      len_eff = key_len_r;
    end
  end

  assign k_last = (LEN_W'(k_r) + LEN_W'(1)) >= len_eff;

  always_comb begin
    case (cmd.rsel)
      RSEL_NEXT: perm_raddr = i_r + PAW'(1);
      RSEL_CUR:  perm_raddr = i_r;
      RSEL_SUMJ: perm_raddr = j_sum;
      RSEL_KS:   perm_raddr = t_addr;
      default:   perm_raddr = i_r;
    endcase
  end

  assign perm_we = cmd.fill || cmd.wr_j || cmd.wr_i;

  always_comb begin
    if (cmd.fill) begin
      perm_waddr = i_r;
      perm_wdata = i_r;
    end else if (cmd.wr_j) begin
      perm_waddr = j_r;
      perm_wdata = sa_r;
    end else begin
      perm_waddr = i_r;
      perm_wdata = sb_r;
    end
  end

  assign key_we = cmd.key_wr && (LEN_W'(in_data.key_index) < KMAX);

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk     (clk),
    .wr_en   (perm_we),
    .wr_addr (perm_waddr),
    .wr_data (perm_wdata),
    .rd_addr (perm_raddr),
    .rd_data (perm_rd)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_MAX_LEN)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (in_data.key_index[KAW-1:0]),
    .wr_data (in_data.key_byte),
    .rd_addr (k_r),
    .rd_data (key_rd)
  );

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (cmd.clr_idx) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else begin
      if (cmd.fill || cmd.inc_i) begin
        i_nxt = i_r + PAW'(1);
      end
      if (cmd.clr_j) begin
        j_nxt = '0;
      end else if (cmd.step_j) begin
        j_nxt = j_sum;
      end
      if (cmd.adv_k) begin
        k_nxt = k_last ? '0 : k_r + KAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      key_len_r   <= KEY_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      if (cfg_valid) begin
        key_len_r <= cfg_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_data) begin
      data_r <= in_data.data_byte;
    end
    if (cmd.step_j) begin
      sa_r <= perm_rd;
    end
    if (cmd.wr_j) begin
      sb_r <= perm_rd;
    end
    if (cmd.wr_i) begin
      hit_r <= (t_addr == i_r);
    end
    if (cmd.load_out) begin
      out_data_r.cipher_byte    <= data_r ^ ks;
      out_data_r.keystream_byte <= ks;
    end
  end

  assign sts.i_last   = (i_r == PAW'(PERM_DEPTH - 1));
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/rc4_stream_cipher.sv
// Data byte: via RJ, W1, W2, KS to the output register; KS waits while the output stalls.
//   One data byte at a time, set by the single read and write port of the permutation RAM
//   (read i, read j, two writes). Key write: stays idle. Restart: busy for fill and schedule.
// Output register lets a finished result wait while the next transaction is taken.
// Reset (sync, active low): not keyed, indices zero, key_length 16; RAMs not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_MAX_LEN = KEY_MAX_LEN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rc4_dp #(
    .KEY_MAX_LEN (KEY_MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/rc4_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4_checker
  import rc4_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction dropped or changed while stalled");

  a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_RESTART |=> !in_ready ##1 !in_ready)
    else $error("input taken during key schedule");

  a_key_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_KEY |=> in_ready)
    else $error("key write left the block busy");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a data transaction in flight");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> sim/rc4_stream_cipher_tb.sv
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SCHED_SETTLE = 1400;
  localparam int HOLD_CYCLES  = 500;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 180;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  // cipher state as the block should hold it
  logic [7:0]       sbox [PERM_DEPTH];
  logic [7:0]       key_mem [KEY_MAX_LEN_DEF];
  bit               key_written [KEY_MAX_LEN_DEF];
  logic [7:0]       si;
  logic [7:0]       sj;
  bit               keyed;
  logic [LEN_W-1:0] key_len_reg;
  out_item_t        ks_expect [$];

  int               err_count;
  int               cycle_count;
  bit               tx_random;
  bit               rx_random;
  bit               rx_hold_req;
  int               rx_wait;

  rc4_stream_cipher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               ks_expect.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned eff_key_len();
    int unsigned n;
    n = 32'(key_len_reg);
    if (n < 1) n = 1;
    if (n > KEY_MAX_LEN_DEF) n = KEY_MAX_LEN_DEF;
    return n;
  endfunction

  function automatic void run_key_schedule();
    int unsigned n_key;
    int unsigned k;
    logic [7:0] jj;
    logic [7:0] t;
    n_key = eff_key_len();
    for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = 8'(n);
    k = 0;
    jj = 8'd0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      jj = jj + sbox[n] + key_mem[k];
      t = sbox[jj];
      sbox[jj] = sbox[n];
      sbox[n] = t;
      k++;
      if (k >= n_key) k = 0;
    end
    si = 8'd0;
    sj = 8'd0;
    keyed = 1'b1;
  endfunction

  function automatic void predict_cipher(in_item_t it);
    logic [7:0] t;
    logic [7:0] pos;
    logic [7:0] ks;
    out_item_t res;
    case (it.opcode)
      OP_KEY: begin
        key_mem[it.key_index] = it.key_byte;
        key_written[it.key_index] = 1'b1;
      end
      OP_RESTART: run_key_schedule();
      OP_DATA: begin
        if (keyed) begin
          si = si + 8'd1;
          sj = sj + sbox[si];
          t = sbox[sj];
          sbox[sj] = sbox[si];
          sbox[si] = t;
          pos = sbox[si] + sbox[sj];
          ks = sbox[pos];
          res.cipher_byte = it.data_byte ^ ks;
          res.keystream_byte = ks;
          ks_expect.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    $display("mismatch %s: got %02h expected %02h at cycle %0d", what, got, want,
             cycle_count);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (ks_expect.size() == 0) begin
        report_mismatch("unexpected result", out_data.cipher_byte, 8'h00);
      end else begin
        want = ks_expect.pop_front();
        if (out_data.cipher_byte !== want.cipher_byte)
          report_mismatch("cipher_byte", out_data.cipher_byte, want.cipher_byte);
        if (out_data.keystream_byte !== want.keystream_byte)
          report_mismatch("keystream_byte", out_data.keystream_byte, want.keystream_byte);
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_wait = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (!rx_random) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_ready <= 1'b1;
      end else if (r < 95) begin
        out_ready <= 1'b0;
        rx_wait = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        rx_wait = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!tx_random) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_cipher(it);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    it.opcode = op;
    it.key_index = 8'($urandom);
    it.key_byte = 8'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  task automatic send_key(logic [7:0] idx, logic [7:0] kb);
    in_item_t it;
    it = rand_item(OP_KEY);
    it.key_index = idx;
    it.key_byte = kb;
    send_item(it);
  endtask

  task automatic send_data(logic [7:0] db);
    in_item_t it;
    it = rand_item(OP_DATA);
    it.data_byte = db;
    send_item(it);
  endtask

  // the schedule may only read key bytes that were written
  task automatic send_restart();
    int unsigned n_key;
    n_key = eff_key_len();
    for (int unsigned idx = 0; idx < n_key; idx++)
      if (!key_written[idx]) send_key(8'(idx), 8'($urandom));
    send_item(rand_item(OP_RESTART));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ks_expect.size() != 0);
  endtask

  task automatic write_key_length(logic [LEN_W-1:0] v);
    wait_drain();
    repeat (SCHED_SETTLE) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_len_reg = v;
  endtask

  task automatic test_unkeyed_traffic();
    send_data(8'h00);
    send_data(8'hFF);
    send_item(rand_item(OP_UNUSED));
    send_data(8'($urandom));
  endtask

  task automatic test_default_key();
    for (int n = 0; n < 16; n++)
      send_key(8'(n), (n == 0) ? 8'h00 : (n == 15) ? 8'hFF : 8'(n * 37));
    send_restart();
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h55);
    send_data(8'hAA);
    send_item(rand_item(OP_UNUSED));
    send_data(8'($urandom));
  endtask

  task automatic test_key_write_midstream();
    send_data(8'($urandom));
    send_key(8'd3, 8'hA5);
    send_key(8'd255, 8'h5A);
    send_data(8'($urandom));
    send_data(8'($urandom));
    send_restart();
    send_data(8'($urandom));
    send_data(8'($urandom));
  endtask

  task automatic test_key_length_sweep();
    logic [LEN_W-1:0] lens [6];
    lens = '{9'd1, 9'd0, 9'd511, 9'd256, 9'd300, 9'd3};
    foreach (lens[n]) begin
      write_key_length(lens[n]);
      if (lens[n] == 9'd3) begin
        send_key(8'd0, 8'h4B);
        send_key(8'd1, 8'h65);
        send_key(8'd2, 8'h79);
      end
      send_restart();
      repeat (6) send_data(8'($urandom));
    end
  endtask

  task automatic test_rekey();
    send_data(8'($urandom));
    send_restart();
    send_restart();
    repeat (4) send_data(8'($urandom));
  endtask

  task automatic test_output_backpressure();
    bit saved;
    saved = tx_random;
    tx_random = 1'b0;
    rx_hold_req = 1'b1;
    repeat (30) send_data(8'($urandom));
    tx_random = saved;
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int r;
    int n_phase;
    logic [LEN_W-1:0] len;
    n_phase = RANDOM_ITEMS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      tx_random = (ph != 0);
      rx_random = (ph != 0);
      if (ph > 0) begin
        r = $urandom_range(0, 9);
        case (r)
          0: len = 9'd0;
          1: len = 9'd511;
          2: len = 9'd256;
          3: len = 9'd1;
          4: len = 9'($urandom_range(257, 511));
          default: len = 9'($urandom_range(1, 64));
        endcase
        write_key_length(len);
        send_restart();
      end
      for (int n = 0; n < n_phase; n++) begin
        r = $urandom_range(0, 99);
        if (r < 72) send_data(8'($urandom));
        else if (r < 84) send_item(rand_item(OP_KEY));
        else if (r < 90) send_restart();
        else if (r < 95) send_item(rand_item(OP_UNUSED));
        else send_data(($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
      end
    end
    tx_random = 1'b1;
    rx_random = 1'b1;
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    tx_random = 1'b1;
    rx_random = 1'b1;
    rx_hold_req = 1'b0;
    keyed = 1'b0;
    si = 8'd0;
    sj = 8'd0;
    key_len_reg = KEY_LEN_RST;
    foreach (key_written[n]) key_written[n] = 1'b0;
    foreach (key_mem[n]) key_mem[n] = 8'h00;
    foreach (sbox[n]) sbox[n] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unkeyed_traffic();
    test_default_key();
    test_key_write_midstream();
    test_rekey();
    test_output_backpressure();
    test_key_length_sweep();
    test_random_traffic();
    wait_drain();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> rc4_stream_cipher.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_ctrl.sv
rtl/core/rc4_dp.sv
rtl/core/rc4_stream_cipher.sv
rtl/core/rc4_checker.sv
sim/rc4_stream_cipher_tb.sv
